// ----- hw/rtl/camera_center_from_pose_core_macros.svh -----
// Assertion macros used by the camera center queue.
`ifndef CAMERA_CENTER_FROM_POSE_CORE_MACROS_SVH
`define CAMERA_CENTER_FROM_POSE_CORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define CCP_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger at one edge implies the condition at the next edge.
`define CCP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- hw/rtl/ccp_pkg.sv -----
// Types and constants of the camera center block.
package ccp_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int TRANS_WIDTH    = 32;
    localparam int QUAT_WIDTH     = 16;

    localparam int QPROD_W   = 2 * QUAT_WIDTH;
    localparam int SHIFT     = 2 * QUAT_FRAC_BITS;
    localparam int ENT_W     = (SHIFT + 2 > QPROD_W + 2) ? SHIFT + 2 : QPROD_W + 2;
    localparam int PROD_W    = ENT_W + TRANS_WIDTH;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_W     = SUM_W + 2;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
    typedef logic signed [TRANS_WIDTH-1:0] trans_t;
    typedef logic signed [QPROD_W-1:0]     qprod_t;
    typedef logic signed [ENT_W-1:0]       ent_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [RND_W-1:0]       rnd_t;

    localparam ent_t   ENT_ONE   = ent_t'(1) << SHIFT;
    localparam rnd_t   RND_HALF  = rnd_t'(1) << (SHIFT - 1);
    localparam trans_t TRANS_MAX = {1'b0, {(TRANS_WIDTH-1){1'b1}}};
    localparam trans_t TRANS_MIN = {1'b1, {(TRANS_WIDTH-1){1'b0}}};

    // ent[3*c + k] is row k of column c of R, i.e. row c, column k of R^T.
    typedef struct packed {
        ent_t   [8:0] ent;
        trans_t [2:0] trans;
    } ccp_job_t;

    typedef struct packed {
        trans_t center_x;
        trans_t center_y;
        trans_t center_z;
        logic   saturated;
    } ccp_result_t;

endpackage

// ----- hw/rtl/ccp_if.sv -----
// Valid/ready channels for pose items and camera center items.
interface ccp_pose_if;
    logic           valid;
    logic           ready;
    ccp_pkg::quat_t  quat_w;
    ccp_pkg::quat_t  quat_x;
    ccp_pkg::quat_t  quat_y;
    ccp_pkg::quat_t  quat_z;
    ccp_pkg::trans_t trans_x;
    ccp_pkg::trans_t trans_y;
    ccp_pkg::trans_t trans_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z,
        output ready
    );
endinterface

interface ccp_center_if;
    logic            valid;
    logic            ready;
    ccp_pkg::trans_t center_x;
    ccp_pkg::trans_t center_y;
    ccp_pkg::trans_t center_z;
    logic            saturated;

    modport source (
        output valid, center_x, center_y, center_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, saturated,
        output ready
    );
endinterface

// ----- hw/rtl/ccp_front.sv -----
// Front end: accepts poses and builds the transposed rotation matrix.
module ccp_front (
    input  logic              clk,
    input  logic              rst_n,
    ccp_pose_if.sink          pose,
    input  logic              full,
    output logic              job_valid,
    output ccp_pkg::ccp_job_t job
);
    import ccp_pkg::*;

    logic   valid_reg;
    logic   adv;
    qprod_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    trans_t tx_reg, ty_reg, tz_reg;

    assign adv        = !valid_reg || !full;
    assign pose.ready = adv;
    assign job_valid  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= pose.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && pose.valid)
        begin
            xx_reg <= pose.quat_x * pose.quat_x;
            yy_reg <= pose.quat_y * pose.quat_y;
            zz_reg <= pose.quat_z * pose.quat_z;
            xy_reg <= pose.quat_x * pose.quat_y;
            xz_reg <= pose.quat_x * pose.quat_z;
            yz_reg <= pose.quat_y * pose.quat_z;
            wx_reg <= pose.quat_w * pose.quat_x;
            wy_reg <= pose.quat_w * pose.quat_y;
            wz_reg <= pose.quat_w * pose.quat_z;
            tx_reg <= pose.trans_x;
            ty_reg <= pose.trans_y;
            tz_reg <= pose.trans_z;
        end
    end

    always_comb
    begin
        job.ent[0] = ENT_ONE - ((ent_t'(yy_reg) + ent_t'(zz_reg)) <<< 1);
        job.ent[1] = (ent_t'(xy_reg) + ent_t'(wz_reg)) <<< 1;
        job.ent[2] = (ent_t'(xz_reg) - ent_t'(wy_reg)) <<< 1;
        job.ent[3] = (ent_t'(xy_reg) - ent_t'(wz_reg)) <<< 1;
        job.ent[4] = ENT_ONE - ((ent_t'(xx_reg) + ent_t'(zz_reg)) <<< 1);
        job.ent[5] = (ent_t'(yz_reg) + ent_t'(wx_reg)) <<< 1;
        job.ent[6] = (ent_t'(xz_reg) + ent_t'(wy_reg)) <<< 1;
        job.ent[7] = (ent_t'(yz_reg) - ent_t'(wx_reg)) <<< 1;
        job.ent[8] = ENT_ONE - ((ent_t'(xx_reg) + ent_t'(yy_reg)) <<< 1);
        job.trans[0] = tx_reg;
        job.trans[1] = ty_reg;
        job.trans[2] = tz_reg;
    end

endmodule

// ----- hw/rtl/ccp_fifo.sv -----
// Short queue of matrix jobs between front end and back end.
`include "camera_center_from_pose_core_macros.svh"

module ccp_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ccp_pkg::ccp_job_t in_data,
    output logic              full,
    input  logic              out_ready,
    output logic              out_valid,
    output ccp_pkg::ccp_job_t out_data
);
    import ccp_pkg::*;

    ccp_job_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic                 push, pop;

    assign full      = count_reg == FIFO_CW'(FIFO_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && !full;
    assign pop       = out_ready && out_valid;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    `CCP_ASSERT_HOLDS(a_count_bound, count_reg <= FIFO_CW'(FIFO_DEPTH), "queue count above depth")
    `CCP_ASSERT_HOLDS(a_ptr_match, FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0], "queue pointers disagree with count")
    `CCP_ASSERT_NEXT(a_push_grow, push && !pop, count_reg == $past(count_reg) + 1'b1, "push did not grow queue")
    `CCP_ASSERT_NEXT(a_pop_shrink, pop && !push, count_reg == $past(count_reg) - 1'b1, "pop did not shrink queue")

endmodule

// ----- hw/rtl/ccp_back.sv -----
// Back end: matrix-vector product, rounding and saturation pipeline.
module ccp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  ccp_pkg::ccp_job_t job,
    output logic              job_ready,
    ccp_center_if.source      center
);
    import ccp_pkg::*;

    logic          en;
    logic          v1_reg, v2_reg, v3_reg, out_valid_reg;
    prod_t [8:0]   prod_reg;
    sum_t  [2:0]   sum_reg;
    rnd_t  [2:0]   rnd_reg;
    rnd_t  [2:0]   shr;
    trans_t [2:0]  clip;
    logic  [2:0]   hit;
    ccp_result_t   res_reg, res_next;

    assign en        = !out_valid_reg || center.ready;
    assign job_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= job_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[3*c+k] <= prod_t'(job.ent[3*c+k]) * prod_t'(job.trans[k]);
                end
                sum_reg[c] <= sum_t'(prod_reg[3*c]) + sum_t'(prod_reg[3*c+1])
                            + sum_t'(prod_reg[3*c+2]);
                rnd_reg[c] <= RND_HALF - rnd_t'(sum_reg[c]);
            end
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            shr[c] = rnd_reg[c] >>> SHIFT;
            if (shr[c] > rnd_t'(TRANS_MAX))
            begin
                clip[c] = TRANS_MAX;
                hit[c]  = 1'b1;
            end
            else if (shr[c] < rnd_t'(TRANS_MIN))
            begin
                clip[c] = TRANS_MIN;
                hit[c]  = 1'b1;
            end
            else
            begin
                clip[c] = shr[c][TRANS_WIDTH-1:0];
                hit[c]  = 1'b0;
            end
        end
        res_next.center_x  = clip[0];
        res_next.center_y  = clip[1];
        res_next.center_z  = clip[2];
        res_next.saturated = |hit;
    end

    assign center.valid     = out_valid_reg;
    assign center.center_x  = res_reg.center_x;
    assign center.center_y  = res_reg.center_y;
    assign center.center_z  = res_reg.center_z;
    assign center.saturated = res_reg.saturated;

endmodule

// ----- hw/rtl/camera_center_from_pose_core.sv -----
// Camera center C = -R^T * T from a pose quaternion (Q2.14) and translation (Q16.16),
// rounded half up and saturated to 32 bits with a flag. One pose is taken per clock while
// the queue is not full. The front end forms the nine matrix entries in one registered
// stage, a four-entry queue decouples it from the back end, and the back end runs nine
// 34x32 multipliers, a three-term sum, the rounding subtract and the saturation in four
// registered stages, the last one the output register. Nothing is kept between poses,
// and the quaternion is used unnormalized.
module camera_center_from_pose_core (
    input  logic          clk,
    input  logic          rst_n,
    ccp_pose_if.sink      pose,
    ccp_center_if.source  center
);
    import ccp_pkg::*;

    logic     job_valid, full, q_valid, q_ready;
    ccp_job_t job, q_job;

    ccp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pose      (pose),
        .full      (full),
        .job_valid (job_valid),
        .job       (job)
    );

    ccp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job_valid),
        .in_data   (job),
        .full      (full),
        .out_ready (q_ready),
        .out_valid (q_valid),
        .out_data  (q_job)
    );

    ccp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job),
        .job_ready (q_ready),
        .center    (center)
    );

endmodule
